// File: src/tird_pkg.sv
// ----------------------------------------------------------------------------
// tird_pkg: shared types for the tape image record deframer
// Phase encoding, result kind codes, the result beat struct and the
// little-endian byte placement helper used for length fields.
// ----------------------------------------------------------------------------
package tird_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DATA    = 2'd1,
    PH_TRAILER = 2'd2,
    PH_PAD     = 2'd3
  } phase_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_MARK  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // One result beat
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] record_length;
    logic [31:0] mismatch_length;
  } result_t;

  // Place byte b at byte lane idx of acc (little endian)
  function automatic logic [31:0] place_byte(input logic [31:0] acc,
                                             input logic [7:0]  b,
                                             input logic [1:0]  idx);
    logic [31:0] r;
    begin
      case (idx)
        2'd0:    r = acc | {24'd0, b};
        2'd1:    r = acc | {16'd0, b, 8'd0};
        2'd2:    r = acc | {8'd0, b, 16'd0};
        default: r = acc | {b, 24'd0};
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/tird_core.sv
// ----------------------------------------------------------------------------
// tird_core: record parsing state machine
// Consumes one byte per enabled cycle, updates the phase and length
// registers and presents the result beat (if any) combinationally.
// ----------------------------------------------------------------------------
module tird_core import tird_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_en,
  input  logic [7:0] octet,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [31:0] trl_r, trl_nxt;
  logic [31:0] rem_r, rem_nxt;

  logic [31:0] hdr_acc;
  logic [31:0] trl_acc;
  logic [31:0] trl_pad;
  logic [31:0] rem_dec;

  // Datapath helpers
  assign hdr_acc = place_byte((idx_r == 2'd0) ? 32'd0 : hdr_r, octet, idx_r);
  assign trl_acc = place_byte((idx_r == 2'd0) ? 32'd0 : trl_r, octet, idx_r);
  assign trl_pad = {octet, trl_r[31:8]};
  assign rem_dec = rem_r - 32'd1;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    hdr_nxt   = hdr_r;
    trl_nxt   = trl_r;
    rem_nxt   = rem_r;
    if (beat_en) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_nxt = hdr_acc;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3 && hdr_acc != 32'd0 && !hdr_acc[31]) begin
            rem_nxt   = hdr_acc;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_nxt = PH_TRAILER;
            idx_nxt   = 2'd0;
          end
        end
        PH_TRAILER: begin
          trl_nxt = trl_acc;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            if (trl_acc != hdr_r && hdr_r[0]) phase_nxt = PH_PAD;
            else                              phase_nxt = PH_HEADER;
          end
        end
        PH_PAD: begin
          trl_nxt   = trl_pad;
          phase_nxt = PH_HEADER;
          idx_nxt   = 2'd0;
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Result beat
  always_comb begin
    res                 = '0;
    res.kind            = KIND_DATA;
    res.record_length   = hdr_r;
    if (beat_en) begin
      unique case (phase_r)
        PH_HEADER: begin
          res.record_length = hdr_acc;
          if (idx_r == 2'd3) begin
            if (hdr_acc == 32'd0) begin
              res.valid = 1'b1;
              res.kind  = KIND_MARK;
            end else if (hdr_acc[31]) begin
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
            end
          end
        end
        PH_DATA: begin
          res.valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = octet;
        end
        PH_TRAILER: begin
          if (idx_r == 2'd3) begin
            if (trl_acc == hdr_r) begin
              res.valid = 1'b1;
              res.kind  = KIND_DONE;
            end else if (!hdr_r[0]) begin
              res.valid           = 1'b1;
              res.kind            = KIND_ERROR;
              res.mismatch_length = trl_acc;
            end
          end
        end
        PH_PAD: begin
          res.valid = 1'b1;
          if (trl_pad == hdr_r) begin
            res.kind = KIND_DONE;
          end else begin
            res.kind            = KIND_ERROR;
            res.mismatch_length = trl_pad;
          end
        end
        default: res.valid = 1'b0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= 32'd0;
      trl_r <= 32'd0;
      rem_r <= 32'd0;
    end else begin
      hdr_r <= hdr_nxt;
      trl_r <= trl_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// File: src/tape_image_record_deframer.sv
// ----------------------------------------------------------------------------
// tape_image_record_deframer: tape image byte stream to record beats
// Splits a length-framed tape image stream into data bytes, record done,
// tape mark and format error reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_octet carries one raw stream byte per
//   beat. Output channel out_valid/out_stall carries zero or one result beat
//   per input byte: out_kind, out_data_byte, out_record_length and
//   out_mismatch_length.
//   Throughput is one byte per cycle while in_stall is low. The result of an
//   accepted byte is registered in the output register (or skid register).
//   The first three header and trailer bytes, the last byte of a valid header
//   and a mismatched odd-record trailer (before its pad byte) produce no result.
//   When the receiver stalls, the output register holds its beat and one
//   more result lands in a skid register; in_stall is high while the skid
//   register is full, i.e. from the cycle after it fills until the cycle
//   after the receiver takes the held beat.
//   Synchronous reset (rst_n low) returns the parser to the header phase
//   and empties both output registers.
// ----------------------------------------------------------------------------
module tape_image_record_deframer import tird_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_octet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_record_length,
  output logic [31:0] out_mismatch_length
);

  logic    in_beat;
  logic    out_free;
  result_t res;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  assign in_stall = skid_r.valid;
  assign in_beat  = in_valid && !skid_r.valid;
  assign out_free = !out_r.valid || !out_stall;

  tird_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (in_beat),
    .octet   (in_octet),
    .res     (res)
  );

  // Output register and skid steering
  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (out_free) begin
      if (skid_r.valid) begin
        out_nxt        = skid_r;
        skid_nxt.valid = 1'b0;
      end else begin
        out_nxt = res;
      end
    end else if (res.valid) begin
      skid_nxt = res;
    end
  end

  // Output and skid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r  <= '0;
      skid_r <= '0;
    end else begin
      out_r  <= out_nxt;
      skid_r <= skid_nxt;
    end
  end

  assign out_valid           = out_r.valid;
  assign out_kind            = out_r.kind;
  assign out_data_byte       = out_r.data_byte;
  assign out_record_length   = out_r.record_length;
  assign out_mismatch_length = out_r.mismatch_length;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for tape_image_record_deframer
// Feeds a tape image byte stream built from framed records, tape marks and
// damaged framing, predicts every result beat in the bench and compares the
// DUT output field by field, with random idle and stall bursts on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tird_pkg::*;

  localparam int STUCK_LIMIT = 1000;  // cycles with no beat on either side
  localparam int TAIL_BYTES  = 150;   // last part of the stream runs without gaps
  localparam int STREAM_LEN  = 1850;

  // Expected result beat
  typedef struct {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] record_length;
    logic [31:0] mismatch_length;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_octet = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [31:0] out_record_length;
  logic [31:0] out_mismatch_length;

  logic [7:0] stream_bytes[$];
  beat_t      expected_beats[$];
  int         errors = 0;
  int         stuck_cycles = 0;
  int         src_gap = 0;
  int         snk_gap = 0;
  int         calm_timer = 0;
  bit         calm = 1'b0;
  bit         tail = 1'b0;

  // Deframer state mirror
  phase_t      ph = PH_HEADER;
  logic [1:0]  fidx = 2'd0;
  logic [31:0] hdr_len = 32'd0;
  logic [31:0] trl_seen = 32'd0;
  logic [31:0] left_bytes = 32'd0;

  tape_image_record_deframer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_octet            (in_octet),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_record_length   (out_record_length),
    .out_mismatch_length (out_mismatch_length)
  );

  always #5 clk = ~clk;

  task automatic push_beat(input kind_t k, input logic [7:0] d,
                           input logic [31:0] len, input logic [31:0] seen);
    beat_t bt;
    bt.kind = k;
    bt.data_byte = d;
    bt.record_length = len;
    bt.mismatch_length = seen;
    expected_beats.push_back(bt);
  endtask

  // Advance the mirror by one stream byte, queue any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    case (ph)
      PH_HEADER: begin
        if (fidx == 2'd0) hdr_len = 32'd0;
        hdr_len = hdr_len | ({24'd0, b} << {fidx, 3'b000});
        if (fidx != 2'd3) begin
          fidx = fidx + 2'd1;
        end else begin
          fidx = 2'd0;
          if (hdr_len == 32'd0) begin
            push_beat(KIND_MARK, 8'd0, 32'd0, 32'd0);
          end else if (hdr_len[31]) begin
            push_beat(KIND_ERROR, 8'd0, hdr_len, 32'd0);
          end else begin
            left_bytes = hdr_len;
            ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        left_bytes = left_bytes - 32'd1;
        if (left_bytes == 32'd0) begin
          ph = PH_TRAILER;
          fidx = 2'd0;
        end
        push_beat(KIND_DATA, b, hdr_len, 32'd0);
      end
      PH_TRAILER: begin
        if (fidx == 2'd0) trl_seen = 32'd0;
        trl_seen = trl_seen | ({24'd0, b} << {fidx, 3'b000});
        if (fidx != 2'd3) begin
          fidx = fidx + 2'd1;
        end else begin
          fidx = 2'd0;
          if (trl_seen == hdr_len) begin
            ph = PH_HEADER;
            push_beat(KIND_DONE, 8'd0, hdr_len, 32'd0);
          end else if (hdr_len[0]) begin
            // odd record: first trailer byte may have been the pad
            ph = PH_PAD;
          end else begin
            ph = PH_HEADER;
            push_beat(KIND_ERROR, 8'd0, hdr_len, trl_seen);
          end
        end
      end
      default: begin
        trl_seen = {b, trl_seen[31:8]};
        ph = PH_HEADER;
        fidx = 2'd0;
        if (trl_seen == hdr_len) push_beat(KIND_DONE, 8'd0, hdr_len, 32'd0);
        else push_beat(KIND_ERROR, 8'd0, hdr_len, trl_seen);
      end
    endcase
  endtask

  // Little-endian length word
  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stream_bytes.push_back(w[8*i +: 8]);
  endtask

  // Header, random payload, optional pad byte, trailer
  task automatic put_record(input logic [31:0] len, input bit pad,
                            input logic [31:0] trailer);
    put_word(len);
    for (int i = 0; i < len; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
    if (pad) stream_bytes.push_back(8'($urandom_range(0, 255)));
    put_word(trailer);
  endtask

  // Driver: one byte per beat, held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_octet <= 8'h00;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_octet);
      if (!(in_valid && in_stall)) begin
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (!calm && !tail && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (stream_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_octet <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    beat_t bt;
    if (!rst_n) begin
      out_stall <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: kind %0d", out_kind);
          errors++;
        end else begin
          bt = expected_beats.pop_front();
          if (out_kind !== bt.kind) begin
            $error("out_kind: expected %0d, got %0d", bt.kind, out_kind);
            errors++;
          end
          if (out_data_byte !== bt.data_byte) begin
            $error("out_data_byte: expected %0h, got %0h", bt.data_byte, out_data_byte);
            errors++;
          end
          if (out_record_length !== bt.record_length) begin
            $error("out_record_length: expected %0h, got %0h",
                   bt.record_length, out_record_length);
            errors++;
          end
          if (out_mismatch_length !== bt.mismatch_length) begin
            $error("out_mismatch_length: expected %0h, got %0h",
                   bt.mismatch_length, out_mismatch_length);
            errors++;
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap--;
        out_stall <= 1'b1;
      end else if (!calm && !tail && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Calm stretches, tail flag and watchdog
  always @(posedge clk) begin
    tail <= (stream_bytes.size() < TAIL_BYTES);
    if (calm_timer == 0) begin
      calm_timer = $urandom_range(100, 300);
      calm <= ($urandom_range(0, 2) == 0);
    end else begin
      calm_timer--;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int r;
    logic [31:0] len;
    logic [31:0] bad;

    // Directed: tape mark, all-ones header, byte extremes with all-ones trailer,
    // odd record with pad, odd record without pad
    put_word(32'd0);
    put_word(32'hFFFF_FFFF);
    put_word(32'd2);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    put_word(32'hFFFF_FFFF);
    put_record(32'd1, 1'b1, 32'd1);
    put_record(32'd1, 1'b0, 32'd1);

    // Random: mostly well-formed records, some tape marks, the rest damaged framing
    while (stream_bytes.size() < STREAM_LEN) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(1, 24);
      if (r < 55) begin
        put_record(len, len[0] && $urandom_range(0, 1), len);
      end else if (r < 65) begin
        put_word(32'd0);
      end else if (r < 69) begin
        len = $urandom_range(100, 300);
        put_record(len, 1'b0, len);
      end else if (r < 79) begin
        put_word(32'h8000_0000 | $urandom());
      end else begin
        // wrong trailer: fully random or one bit off
        if (r < 90) bad = $urandom();
        else bad = len ^ (32'd1 << $urandom_range(0, 31));
        if (bad == len) bad = ~bad;
        put_record(len, 1'b0, bad);
        if (len[0]) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/tird_pkg.sv
src/tird_core.sv
src/tape_image_record_deframer.sv
tb/tb.sv
